@@ design/ddao_pkg.sv @@
// ----------------------------------------------------------------------------
// Differential drive arc odometry package
// Shared types, fixed-point constants and helper functions.
// ----------------------------------------------------------------------------
package ddao_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CFG_DPR = 2'd0;
  localparam logic [1:0] CFG_TW  = 2'd1;
  localparam logic [1:0] CFG_THR = 2'd2;

  // Configuration reset values.
  localparam logic [23:0] DPR_RESET = 24'd205887;
  localparam logic [23:0] TW_RESET  = 24'd786432;
  localparam logic [15:0] THR_RESET = 16'd537;

  // Angle constants, Q3.29 radians.
  localparam logic signed [34:0] PI_Q29      = 35'sd1686629713;
  localparam logic signed [34:0] TWO_PI_Q29  = 35'sd3373259426;
  localparam logic signed [34:0] HALF_PI_Q29 = 35'sd843314857;

  // CORDIC gain compensation, Q2.30.
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic [4:0]         CORDIC_LAST = 5'd29;

  // Heading conversion from hundredths of a degree. The pi constant is split
  // as 18000 * HD_QUOT + HD_REM, so only the small remainder term needs a
  // division by 18000, done as a multiply by a rounded-up reciprocal / 2^44.
  localparam logic [15:0] IMU_WRAP = 16'd36000;
  localparam logic [32:0] HD_QUOT  = 33'd93701;
  localparam logic [32:0] HD_REM   = 33'd11713;
  localparam logic [32:0] HD_ROUND = 33'd9000;
  localparam logic [32:0] HD_RECIP = 33'd977343670;

  // Divider step count.
  localparam logic [6:0] DIV_STEPS = 7'd64;

  // Datapath operations, one per cycle.
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_L,
    OP_DIST_L,
    OP_MUL_R,
    OP_DIST_R,
    OP_DIV_TH,
    OP_DTH,
    OP_COR_TH,
    OP_COR_HALF,
    OP_MUL_SH,
    OP_DIV_CH,
    OP_MUL_WS,
    OP_CHORD,
    OP_COR_SUM,
    OP_MUL_XS,
    OP_ACC_X,
    OP_MUL_YC,
    OP_ACC_Y,
    OP_MUL_HD,
    OP_DIV_HD,
    OP_MUL_HQ,
    OP_HD
  } dp_op_t;

  // Controller states.
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_MUL_L,
    ST_DIST_L,
    ST_MUL_R,
    ST_DIST_R,
    ST_DIV_TH,
    ST_WAIT_TH,
    ST_DTH,
    ST_BRANCH,
    ST_COR_TH,
    ST_COR_HALF,
    ST_WAIT_HALF,
    ST_MUL_SH,
    ST_DIV_CH,
    ST_WAIT_CH,
    ST_MUL_WS,
    ST_CHORD,
    ST_COR_SUM,
    ST_WAIT_COR,
    ST_MUL_X,
    ST_ACC_X,
    ST_MUL_Y,
    ST_ACC_Y,
    ST_MUL_HD,
    ST_DIV_HD,
    ST_MUL_HQ,
    ST_OUT
  } ctrl_state_t;

  // CORDIC unit phases.
  typedef enum logic [1:0] {
    COR_IDLE,
    COR_REDUCE,
    COR_FOLD,
    COR_ITER
  } cor_phase_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_busy;
    logic cor_busy;
    logic straight;
    logic out_free;
  } stat_t;

  // Clamp a 64-bit signed value to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Rotation angle of one CORDIC step, Q2.30.
  function automatic logic signed [33:0] cordic_step(input logic [4:0] i);
    logic signed [33:0] r;
    case (i)
      5'd0:  r = 34'sd843314857;
      5'd1:  r = 34'sd497837829;
      5'd2:  r = 34'sd263043837;
      5'd3:  r = 34'sd133525159;
      5'd4:  r = 34'sd67021687;
      5'd5:  r = 34'sd33543516;
      5'd6:  r = 34'sd16775851;
      5'd7:  r = 34'sd8388437;
      5'd8:  r = 34'sd4194283;
      5'd9:  r = 34'sd2097149;
      5'd10: r = 34'sd1048576;
      default: r = 34'sd1 <<< (5'd30 - i);
    endcase
    return r;
  endfunction

endpackage

@@ design/differential_drive_arc_odometry.sv @@
// One item is in work at a time. The iterative divider (run once for a
// straight update, twice for an arc) and the 30-step CORDIC (one or two
// runs) set how long an update takes; a stalled result adds its wait.
// Reset (rst, synchronous) clears the pose and previous distances and loads
// the configuration defaults; it needs no clearing pass.
// ----------------------------------------------------------------------------
// Differential drive arc odometry
// Top level: controller and datapath with stall-style item channels.
// ----------------------------------------------------------------------------
module differential_drive_arc_odometry import ddao_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] left_rotations,
  input  logic signed [31:0] right_rotations,
  input  logic [15:0]        imu_heading,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] pose_x,
  output logic signed [31:0] pose_y,
  output logic [31:0]        pose_heading,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [23:0]        cfg_data
);

  dp_op_t op;
  stat_t  stat;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  ddao_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .op       (op)
  );

  ddao_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .op              (op),
    .stat            (stat),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .left_rotations  (left_rotations),
    .right_rotations (right_rotations),
    .imu_heading     (imu_heading),
    .pose_x          (pose_x),
    .pose_y          (pose_y),
    .pose_heading    (pose_heading),
    .out_valid       (out_valid),
    .out_stall       (out_stall)
  );

`ifndef ASSERT_OFF
  // A new item never arrives while a shared unit is still running.
  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |-> (!stat.div_busy && !stat.cor_busy))
    else $error("item transfer while an arithmetic unit is busy");

  // The divider and the CORDIC unit never run at the same time.
  a_units_exclusive: assert property (@(posedge clk) disable iff (rst)
    stat.div_busy |-> !stat.cor_busy)
    else $error("divider and CORDIC busy together");

  // A result is loaded only when the output register is free.
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    (op == OP_HD) |-> stat.out_free)
    else $error("result loaded over an undelivered one");
`endif

endmodule

@@ design/ddao_div.sv @@
// ----------------------------------------------------------------------------
// Iterative signed divider
// Restoring division on magnitudes, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
module ddao_div import ddao_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] dividend,
  input  logic signed [32:0] divisor,
  output logic               busy,
  output logic signed [63:0] quotient
);

  logic [6:0]  cnt;
  logic [63:0] dq;
  logic [32:0] rem;
  logic [32:0] vmag;
  logic        neg;
  logic [33:0] trial;
  logic        fits;

  // Shift in the next dividend bit and compare against the divisor.
  assign trial = {rem, dq[63]};
  assign fits  = trial >= {1'b0, vmag};

  // Busy flag and step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= 7'd0;
    end else if (!busy) begin
      if (start) begin
        busy <= 1'b1;
        cnt  <= 7'd0;
      end
    end else if (cnt == DIV_STEPS) begin
      busy <= 1'b0;
    end else begin
      cnt <= cnt + 7'd1;
    end
  end

  // Magnitude registers and the signed result.
  always_ff @(posedge clk) begin
    if (!busy) begin
      if (start) begin
        dq   <= dividend[63] ? (~dividend + 64'd1) : dividend;
        vmag <= divisor[32] ? (~divisor + 33'd1) : divisor;
        neg  <= dividend[63] ^ divisor[32];
        rem  <= 33'd0;
      end
    end else if (cnt == DIV_STEPS) begin
      quotient <= neg ? (~dq + 64'd1) : dq;
    end else if (fits) begin
      rem <= 33'(trial - {1'b0, vmag});
      dq  <= {dq[62:0], 1'b1};
    end else begin
      rem <= trial[32:0];
      dq  <= {dq[62:0], 1'b0};
    end
  end

endmodule

@@ design/ddao_cordic.sv @@
// ----------------------------------------------------------------------------
// Iterative CORDIC sine and cosine
// Reduces a Q3.29 angle by quadrant, then runs 30 rotation steps.
// ----------------------------------------------------------------------------
module ddao_cordic import ddao_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [34:0] angle,
  output logic               busy,
  output logic signed [31:0] sin_out,
  output logic signed [31:0] cos_out
);

  cor_phase_t         phase;
  logic signed [34:0] a;
  logic               neg;
  logic signed [33:0] x;
  logic signed [33:0] y;
  logic signed [33:0] z;
  logic [4:0]         i;
  logic signed [34:0] af;
  logic               nf;
  logic signed [33:0] xs;
  logic signed [33:0] ys;
  logic signed [33:0] step;
  logic signed [33:0] xn;

  // Fold the angle into the right half plane.
  always_comb begin
    af = a;
    nf = 1'b0;
    if (a > HALF_PI_Q29) begin
      af = PI_Q29 - a;
      nf = 1'b1;
    end else if (a < -HALF_PI_Q29) begin
      af = -PI_Q29 - a;
      nf = 1'b1;
    end
  end

  // Shifted terms of the current rotation step.
  assign xs   = x >>> i;
  assign ys   = y >>> i;
  assign step = cordic_step(i);

  // Phase sequencing.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= COR_IDLE;
    end else begin
      case (phase)
        COR_IDLE: begin
          if (start) phase <= COR_REDUCE;
        end
        COR_REDUCE: begin
          if (!a[34] && a < TWO_PI_Q29) phase <= COR_FOLD;
        end
        COR_FOLD: phase <= COR_ITER;
        COR_ITER: begin
          if (i == CORDIC_LAST) phase <= COR_IDLE;
        end
        default: phase <= COR_IDLE;
      endcase
    end
  end

  // Angle reduction and rotation registers.
  always_ff @(posedge clk) begin
    case (phase)
      COR_IDLE: begin
        if (start) a <= angle;
      end
      COR_REDUCE: begin
        if (a[34]) begin
          a <= a + TWO_PI_Q29;
        end else if (a >= TWO_PI_Q29) begin
          a <= a - TWO_PI_Q29;
        end else if (a > PI_Q29) begin
          a <= a - TWO_PI_Q29;
        end
      end
      COR_FOLD: begin
        z   <= {af[32:0], 1'b0};
        x   <= CORDIC_GAIN;
        y   <= 34'sd0;
        i   <= 5'd0;
        neg <= nf;
      end
      COR_ITER: begin
        if (!z[33]) begin
          x <= x - ys;
          y <= y + xs;
          z <= z - step;
        end else begin
          x <= x + ys;
          y <= y - xs;
          z <= z + step;
        end
        i <= i + 5'd1;
      end
      default: ;
    endcase
  end

  assign busy    = phase != COR_IDLE;
  assign xn      = -x;
  assign sin_out = y[31:0];
  assign cos_out = neg ? xn[31:0] : x[31:0];

endmodule

@@ design/ddao_dp.sv @@
// ----------------------------------------------------------------------------
// Odometry datapath
// Pose state, configuration, shared multiplier, divider and CORDIC unit.
// ----------------------------------------------------------------------------
module ddao_dp import ddao_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  dp_op_t             op,
  output stat_t              stat,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  input  logic signed [31:0] left_rotations,
  input  logic signed [31:0] right_rotations,
  input  logic [15:0]        imu_heading,
  output logic signed [31:0] pose_x,
  output logic signed [31:0] pose_y,
  output logic [31:0]        pose_heading,
  output logic               out_valid,
  input  logic               out_stall
);

  logic [23:0]        dpr;
  logic [23:0]        tw;
  logic [15:0]        thr;
  logic signed [31:0] lin;
  logic signed [31:0] rin;
  logic [15:0]        imu;
  logic [31:0]        last_left;
  logic [31:0]        last_right;
  logic [31:0]        px;
  logic [31:0]        py;
  logic [31:0]        hd;
  logic signed [31:0] dl;
  logic signed [31:0] dr;
  logic signed [31:0] dth;
  logic signed [31:0] sh;
  logic signed [31:0] travel;
  logic signed [65:0] p;
  logic [14:0]        hq;

  logic [23:0]        w_eff;
  logic signed [32:0] ma;
  logic signed [32:0] mb;
  logic signed [65:0] prod;
  logic               mul_en;
  logic [31:0]        dist_new;
  logic signed [32:0] diff33;
  logic signed [32:0] sum33;
  logic signed [31:0] half;
  logic [31:0]        mag;
  logic signed [63:0] chord_sum;
  logic [31:0]        hd_new;

  logic               div_start;
  logic signed [63:0] div_dvd;
  logic signed [32:0] div_dsr;
  logic               div_busy;
  logic signed [63:0] div_q;

  logic               cor_start;
  logic signed [34:0] cor_angle;
  logic               cor_busy;
  logic signed [31:0] cor_s;
  logic signed [31:0] cor_c;

  // Derived values.
  assign w_eff     = (tw == 24'd0) ? 24'd1 : tw;
  assign dist_new  = p[47:16];
  assign diff33    = {dl[31], dl} - {dr[31], dr};
  assign sum33     = {dl[31], dl} + {dr[31], dr};
  assign half      = dth >>> 1;
  assign mag       = dth[31] ? (~dth + 32'd1) : dth;
  assign chord_sum = div_q + {{28{p[65]}}, p[65:30]};
  assign hd_new    = p[31:0] + {17'd0, hq};

  // Multiplier operand selection.
  always_comb begin
    ma = 33'sd0;
    mb = 33'sd0;
    case (op)
      OP_MUL_L: begin
        ma = {lin[31], lin};
        mb = {9'd0, dpr};
      end
      OP_MUL_R: begin
        ma = {rin[31], rin};
        mb = {9'd0, dpr};
      end
      OP_MUL_SH: begin
        ma = {dr[31], dr};
        mb = {cor_s[31], cor_s};
      end
      OP_MUL_WS: begin
        ma = {9'd0, w_eff};
        mb = {sh[31], sh};
      end
      OP_MUL_XS: begin
        ma = {travel[31], travel};
        mb = {cor_s[31], cor_s};
      end
      OP_MUL_YC: begin
        ma = {travel[31], travel};
        mb = {cor_c[31], cor_c};
      end
      OP_MUL_HD: begin
        ma = {17'd0, imu};
        mb = HD_REM;
      end
      // Remainder term plus rounding, times the reciprocal of 18000.
      OP_DIV_HD: begin
        ma = {4'd0, p[28:0]} + HD_ROUND;
        mb = HD_RECIP;
      end
      OP_MUL_HQ: begin
        ma = {17'd0, imu};
        mb = HD_QUOT;
      end
      default: ;
    endcase
  end

  assign prod   = ma * mb;
  assign mul_en = op inside {OP_MUL_L, OP_MUL_R, OP_MUL_SH, OP_MUL_WS,
                             OP_MUL_XS, OP_MUL_YC, OP_MUL_HD, OP_DIV_HD,
                             OP_MUL_HQ};

  // Divider operand selection.
  always_comb begin
    div_dvd = 64'sd0;
    div_dsr = 33'sd1;
    case (op)
      OP_DIV_TH: begin
        div_dvd = {{2{diff33[32]}}, diff33, 29'd0};
        div_dsr = {9'd0, w_eff};
      end
      OP_DIV_CH: begin
        div_dvd = p[63:0];
        div_dsr = {dth[31], dth};
      end
      default: ;
    endcase
  end

  assign div_start = op inside {OP_DIV_TH, OP_DIV_CH};

  // CORDIC angle selection.
  always_comb begin
    cor_angle = 35'sd0;
    case (op)
      OP_COR_TH:   cor_angle = {3'b000, hd};
      OP_COR_HALF: cor_angle = {{3{half[31]}}, half};
      OP_COR_SUM:  cor_angle = {3'b000, hd} + {{3{half[31]}}, half};
      default: ;
    endcase
  end

  assign cor_start = op inside {OP_COR_TH, OP_COR_HALF, OP_COR_SUM};

  ddao_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .busy     (div_busy),
    .quotient (div_q)
  );

  ddao_cordic u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (cor_start),
    .angle   (cor_angle),
    .busy    (cor_busy),
    .sin_out (cor_s),
    .cos_out (cor_c)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      dpr <= DPR_RESET;
      tw  <= TW_RESET;
      thr <= THR_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DPR: dpr <= cfg_data;
        CFG_TW:  tw  <= cfg_data;
        CFG_THR: thr <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Pose state, which reset clears.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_left  <= 32'd0;
      last_right <= 32'd0;
      px         <= 32'd0;
      py         <= 32'd0;
      hd         <= 32'd0;
    end else begin
      case (op)
        OP_DIST_L: last_left  <= dist_new;
        OP_DIST_R: last_right <= dist_new;
        OP_ACC_X:  px <= px + p[61:30];
        OP_ACC_Y:  py <= py + p[61:30];
        OP_HD:     hd <= hd_new;
        default: ;
      endcase
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    if (mul_en) p <= prod;
    case (op)
      OP_LOAD: begin
        lin <= left_rotations;
        rin <= right_rotations;
        imu <= (imu_heading >= IMU_WRAP) ? imu_heading - IMU_WRAP : imu_heading;
      end
      OP_DIST_L: dl <= dist_new - last_left;
      OP_DIST_R: dr <= dist_new - last_right;
      OP_DTH: begin
        dth    <= sat32(div_q);
        travel <= sum33[32:1];
      end
      OP_MUL_SH: sh <= cor_s;
      OP_CHORD:  travel <= sat32(chord_sum);
      // Quotient of the remainder term, taken before the product is reused.
      OP_MUL_HQ: hq <= p[58:44];
      default: ;
    endcase
  end

  // Output register, loaded only when the previous result has gone.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (op == OP_HD) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op == OP_HD) begin
      pose_x       <= px;
      pose_y       <= py;
      pose_heading <= hd_new;
    end
  end

  // Status to the controller.
  assign stat.div_busy = div_busy;
  assign stat.cor_busy = cor_busy;
  assign stat.straight = (mag < {16'd0, thr}) || (dth == 32'sd0);
  assign stat.out_free = !out_valid || !out_stall;

endmodule

@@ design/ddao_ctrl.sv @@
// ----------------------------------------------------------------------------
// Odometry controller
// Sequences one update, one op per cycle unless a unit or the output stalls.
// ----------------------------------------------------------------------------
module ddao_ctrl import ddao_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_stall,
  input  stat_t  stat,
  output dp_op_t op
);

  ctrl_state_t state;
  ctrl_state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:      if (in_valid) state_next = ST_MUL_L;
      ST_MUL_L:     state_next = ST_DIST_L;
      ST_DIST_L:    state_next = ST_MUL_R;
      ST_MUL_R:     state_next = ST_DIST_R;
      ST_DIST_R:    state_next = ST_DIV_TH;
      ST_DIV_TH:    state_next = ST_WAIT_TH;
      ST_WAIT_TH:   if (!stat.div_busy) state_next = ST_DTH;
      ST_DTH:       state_next = ST_BRANCH;
      ST_BRANCH:    state_next = stat.straight ? ST_COR_TH : ST_COR_HALF;
      ST_COR_TH:    state_next = ST_WAIT_COR;
      ST_COR_HALF:  state_next = ST_WAIT_HALF;
      ST_WAIT_HALF: if (!stat.cor_busy) state_next = ST_MUL_SH;
      ST_MUL_SH:    state_next = ST_DIV_CH;
      ST_DIV_CH:    state_next = ST_WAIT_CH;
      ST_WAIT_CH:   if (!stat.div_busy) state_next = ST_MUL_WS;
      ST_MUL_WS:    state_next = ST_CHORD;
      ST_CHORD:     state_next = ST_COR_SUM;
      ST_COR_SUM:   state_next = ST_WAIT_COR;
      ST_WAIT_COR:  if (!stat.cor_busy) state_next = ST_MUL_X;
      ST_MUL_X:     state_next = ST_ACC_X;
      ST_ACC_X:     state_next = ST_MUL_Y;
      ST_MUL_Y:     state_next = ST_ACC_Y;
      ST_ACC_Y:     state_next = ST_MUL_HD;
      ST_MUL_HD:    state_next = ST_DIV_HD;
      ST_DIV_HD:    state_next = ST_MUL_HQ;
      ST_MUL_HQ:    state_next = ST_OUT;
      ST_OUT:       if (stat.out_free) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // Datapath command for the current state.
  always_comb begin
    op = OP_NONE;
    case (state)
      ST_IDLE:     op = in_valid ? OP_LOAD : OP_NONE;
      ST_MUL_L:    op = OP_MUL_L;
      ST_DIST_L:   op = OP_DIST_L;
      ST_MUL_R:    op = OP_MUL_R;
      ST_DIST_R:   op = OP_DIST_R;
      ST_DIV_TH:   op = OP_DIV_TH;
      ST_DTH:      op = OP_DTH;
      ST_COR_TH:   op = OP_COR_TH;
      ST_COR_HALF: op = OP_COR_HALF;
      ST_MUL_SH:   op = OP_MUL_SH;
      ST_DIV_CH:   op = OP_DIV_CH;
      ST_MUL_WS:   op = OP_MUL_WS;
      ST_CHORD:    op = OP_CHORD;
      ST_COR_SUM:  op = OP_COR_SUM;
      ST_MUL_X:    op = OP_MUL_XS;
      ST_ACC_X:    op = OP_ACC_X;
      ST_MUL_Y:    op = OP_MUL_YC;
      ST_ACC_Y:    op = OP_ACC_Y;
      ST_MUL_HD:   op = OP_MUL_HD;
      ST_DIV_HD:   op = OP_DIV_HD;
      ST_MUL_HQ:   op = OP_MUL_HQ;
      ST_OUT:      op = stat.out_free ? OP_HD : OP_NONE;
      default:     op = OP_NONE;
    endcase
  end

  assign in_stall = state != ST_IDLE;

endmodule
